### sv/one_wire_master_timing_defines.svh
// Assertion macros shared by the one-wire master timing RTL.
// Included by the top level, which carries the concurrent checks; no other dependencies.
`ifndef ONE_WIRE_MASTER_TIMING_DEFINES_SVH
`define ONE_WIRE_MASTER_TIMING_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define OWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define OWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/owm_pkg.sv
// Package for the one-wire master timing block: widths, phase codes,
// register indexes, result struct and duration helpers. No dependencies.
package owm_pkg;

    // Timer and register geometry
    localparam int TIMER_BITS = 10;
    localparam int CFG_W      = 10;
    localparam int NUM_CFG    = 8;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int CMP_W      = (CFG_W > TIMER_BITS) ? CFG_W : TIMER_BITS;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    typedef logic [NUM_CFG-1:0][CFG_W-1:0] cfg_t;

    // Register indexes
    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [2:0] REG_SLOT_START    = 3'd3;
    localparam logic [2:0] REG_WRITE_HOLD    = 3'd4;
    localparam logic [2:0] REG_RECOVERY      = 3'd5;
    localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [2:0] REG_READ_TAIL     = 3'd7;

    localparam cfg_t CFG_RESET = '{
        10'd50, 10'd12, 10'd2, 10'd60, 10'd2, 10'd410, 10'd70, 10'd480
    };

    // Command codes on the mode field
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_RESET = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_W_START  = 4'd4,
        PH_W_HOLD   = 4'd5,
        PH_W_REC    = 4'd6,
        PH_R_START  = 4'd7,
        PH_R_WAIT   = 4'd8,
        PH_R_TAIL   = 4'd9
    } phase_t;

    // One result item
    typedef struct packed {
        logic       pull;
        logic       busy;
        logic       done;
        logic       no_dev;
        logic [7:0] rdata;
    } res_t;

    // Register that times a given phase
    function automatic logic [2:0] phase_reg_idx(phase_t ph);
        logic [2:0] idx;
        case (ph)
            PH_RST_LOW:  idx = REG_RESET_LOW;
            PH_RST_WAIT: idx = REG_PRESENCE_WAIT;
            PH_RST_TAIL: idx = REG_RESET_TAIL;
            PH_W_START:  idx = REG_SLOT_START;
            PH_R_START:  idx = REG_SLOT_START;
            PH_W_HOLD:   idx = REG_WRITE_HOLD;
            PH_W_REC:    idx = REG_RECOVERY;
            PH_R_WAIT:   idx = REG_READ_SAMPLE;
            default:     idx = REG_READ_TAIL;
        endcase
        return idx;
    endfunction

    // Phase length in ticks: zero counts as one, saturates at the timer max
    function automatic logic [TIMER_BITS-1:0] phase_ticks(logic [CFG_W-1:0] c);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(c);
        if (ext == '0)
        begin
            ext = CMP_W'(1);
        end
        if (ext > CMP_W'(TIMER_MAX))
        begin
            ext = CMP_W'(TIMER_MAX);
        end
        return ext[TIMER_BITS-1:0];
    endfunction

endpackage

### sv/owm_engine.sv
// Bus timing engine: phase state, microsecond counter, bit shifters.
// Computes one result per tick from the state and the tick's inputs; uses owm_pkg.
module owm_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  owm_pkg::cfg_t      cfg,
    input  logic [1:0]         mode,
    input  logic [7:0]         write_data,
    input  logic               line_level,
    output owm_pkg::res_t      res
);
    import owm_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [TIMER_BITS-1:0]   cnt_reg, cnt_next;
    logic [2:0]              bidx_reg, bidx_next;
    logic [7:0]              tx_reg, tx_next;
    logic [7:0]              rx_reg, rx_next;
    logic                    pres_reg, pres_next;

    phase_t                  ph;
    logic [TIMER_BITS-1:0]   cnt_inc;
    logic [TIMER_BITS-1:0]   dur;
    logic                    last_bit;
    logic                    pull, busy, done;

    // Start decode, per-phase outputs, phase advance
    always_comb
    begin
        cnt_next  = cnt_reg;
        bidx_next = bidx_reg;
        tx_next   = tx_reg;
        rx_next   = rx_reg;
        pres_next = pres_reg;
        pull      = 1'b0;
        busy      = 1'b0;
        done      = 1'b0;

        // unused codes fall back to idle
        case (phase_reg)
            PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL,
            PH_W_START, PH_W_HOLD, PH_W_REC,
            PH_R_START, PH_R_WAIT, PH_R_TAIL: ph = phase_reg;
            default:                          ph = PH_IDLE;
        endcase

        // command taken only when idle; its tick is the first of the phase
        if (ph == PH_IDLE && mode != MODE_TICK)
        begin
            cnt_next  = '0;
            bidx_next = '0;
            case (mode)
                MODE_RESET: ph = PH_RST_LOW;
                MODE_WRITE:
                begin
                    ph      = PH_W_START;
                    tx_next = write_data;
                end
                default:
                begin
                    ph      = PH_R_START;
                    rx_next = '0;
                end
            endcase
        end

        phase_next = ph;
        cnt_inc    = cnt_next + TIMER_BITS'(1);
        dur        = phase_ticks(cfg[phase_reg_idx(ph)]);
        last_bit   = (bidx_next == 3'd7);

        if (ph != PH_IDLE)
        begin
            busy = 1'b1;
            case (ph)
                PH_RST_LOW, PH_W_START, PH_R_START: pull = 1'b1;
                PH_W_HOLD:   pull = ~tx_next[0];
                PH_RST_TAIL:
                begin
                    if (cnt_next == '0)
                    begin
                        pres_next = line_level;
                    end
                end
                PH_R_TAIL:
                begin
                    if (cnt_next == '0 && line_level)
                    begin
                        rx_next = rx_next | (8'd1 << bidx_next);
                    end
                end
                default: pull = 1'b0;
            endcase

            if (cnt_inc >= dur)
            begin
                cnt_next = '0;
                case (ph)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT: phase_next = PH_RST_TAIL;
                    PH_RST_TAIL: phase_next = PH_IDLE;
                    PH_W_START:  phase_next = PH_W_HOLD;
                    PH_W_HOLD:   phase_next = PH_W_REC;
                    PH_W_REC:
                    begin
                        tx_next    = {1'b0, tx_next[7:1]};
                        phase_next = last_bit ? PH_IDLE : PH_W_START;
                        bidx_next  = bidx_next + 3'd1;
                    end
                    PH_R_START:  phase_next = PH_R_WAIT;
                    PH_R_WAIT:   phase_next = PH_R_TAIL;
                    default:
                    begin
                        phase_next = last_bit ? PH_IDLE : PH_R_START;
                        bidx_next  = bidx_next + 3'd1;
                    end
                endcase
                done = (phase_next == PH_IDLE);
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
    end

    // State registers advance once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            bidx_reg  <= '0;
            tx_reg    <= '0;
            rx_reg    <= '0;
            pres_reg  <= 1'b1;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            bidx_reg  <= bidx_next;
            tx_reg    <= tx_next;
            rx_reg    <= rx_next;
            pres_reg  <= pres_next;
        end
    end

    assign res.pull   = pull;
    assign res.busy   = busy;
    assign res.done   = done;
    assign res.no_dev = pres_next;
    assign res.rdata  = rx_next;

endmodule

### sv/one_wire_master_timing.sv
// Top level of the one-wire master timing block: register port, tick channel,
// two-entry result buffer. Uses owm_pkg, owm_engine and the assertion macro header.
//
//  channel   direction  handshake          payload
//  tick in   in         in_valid/in_stall  mode, write_data, line_level
//  result    out        out_valid/out_stall line_pull_low, busy_res, done_res,
//                                           no_device, read_data
//  config    in         psel/penable/pwrite paddr, pwdata, prdata (pready tied high)
//
// One tick item is taken per clock while in_stall is low; its result is registered in the result buffer.
// The result buffer holds two items, so a tick is taken while one result waits;
// in_stall rises only when both entries are full.
// Timing state and the registers come out of reset with the default durations.
// Register writes are registered in cfg_reg; the engine reads them on the next tick.
module one_wire_master_timing (
    input  logic                        clk,
    input  logic                        rst_n,
    // tick channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  mode,
    input  logic [7:0]                  write_data,
    input  logic                        line_level,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        line_pull_low,
    output logic                        busy_res,
    output logic                        done_res,
    output logic                        no_device,
    output logic [7:0]                  read_data,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [owm_pkg::ADDR_W-1:0]  paddr,
    input  logic [owm_pkg::DATA_W-1:0]  pwdata,
    output logic [owm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import owm_pkg::*;
    `include "one_wire_master_timing_defines.svh"

    cfg_t        cfg_reg;
    logic [2:0]  reg_idx;
    logic        cfg_wr;

    logic        acc;
    logic        out_fire;
    res_t        res;

    res_t        main_reg, main_next;
    logic        main_valid_reg, main_valid_next;
    res_t        skid_reg, skid_next;
    logic        skid_valid_reg, skid_valid_next;

    // Register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = DATA_W'(cfg_reg[reg_idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr)
        begin
            cfg_reg[reg_idx] <= pwdata[CFG_W-1:0];
        end
    end

    // Tick handshake
    assign in_stall = skid_valid_reg;
    assign acc      = in_valid && !in_stall;
    assign out_fire = main_valid_reg && !out_stall;

    owm_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (acc),
        .cfg        (cfg_reg),
        .mode       (mode),
        .write_data (write_data),
        .line_level (line_level),
        .res        (res)
    );

    // Result buffer: main entry drives the port, skid catches one more
    always_comb
    begin
        main_next       = main_reg;
        main_valid_next = main_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!main_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = res;
                main_valid_next = acc;
            end
        end
        else if (acc)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid     = main_valid_reg;
    assign line_pull_low = main_reg.pull;
    assign busy_res      = main_reg.busy;
    assign done_res      = main_reg.done;
    assign no_device     = main_reg.no_dev;
    assign read_data     = main_reg.rdata;

    // Checks
    `OWM_ASSERT_NOW(a_skid_behind_main, clk, rst_n, skid_valid_reg, main_valid_reg,
        "skid entry held without a main entry")
    `OWM_ASSERT_NOW(a_done_in_op, clk, rst_n, acc && res.done, res.busy,
        "operation finished on a tick outside an operation")
    `OWM_ASSERT_NEXT(a_skid_refills_main, clk, rst_n, skid_valid_reg && out_fire,
        main_valid_reg && !skid_valid_reg, "skid entry lost on drain")
    `OWM_ASSERT_NOW(a_pull_in_op, clk, rst_n, acc && res.pull, res.busy,
        "line driven low outside an operation")

endmodule

### tb/sv/one_wire_master_timing_tb.sv
// Testbench for one_wire_master_timing: sends microsecond tick items carrying bus
// commands, works out each result in step with the block and checks every field.
// Depends on owm_pkg and the one_wire_master_timing RTL.
module one_wire_master_timing_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import owm_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_TICKS = 360;
    localparam int RANDOM_SEGS  = 3;
    localparam int DRAIN_CYCLES = 8;

    // Line level patterns for a bus operation
    localparam int LV_RANDOM = 0;
    localparam int LV_LOW    = 1;
    localparam int LV_HIGH   = 2;

    typedef struct packed {
        logic [1:0] md;
        logic [7:0] wd;
        logic       lvl;
    } tick_t;

    typedef logic [NUM_CFG-1:0][CFG_W-1:0] dur_set_t;

    // DUT ports
    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [1:0]          mode          = MODE_TICK;
    logic [7:0]          write_data    = 8'h00;
    logic                line_level    = 1'b1;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic                line_pull_low;
    logic                busy_res;
    logic                done_res;
    logic                no_device;
    logic [7:0]          read_data;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [DATA_W-1:0]   pwdata        = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Mirror of the bus engine: durations and timing state
    logic [CFG_W-1:0]    dur_reg [NUM_CFG];
    phase_t              ph            = PH_IDLE;
    logic [9:0]          us_cnt        = '0;
    logic [2:0]          bit_idx       = '0;
    logic [7:0]          tx_sh         = '0;
    logic [7:0]          rx_byte       = '0;
    logic                presence      = 1'b1;

    // Item traffic bookkeeping
    tick_t               ticks_to_send [$];
    res_t                due_results [$];
    int                  ticks_queued  = 0;
    int                  results_seen  = 0;
    int                  fail_count    = 0;
    int                  cycles        = 0;
    bit                  in_pace       = 1'b1;
    bit                  out_pace      = 1'b1;
    int                  hold_reqs     = 0;

    one_wire_master_timing dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .write_data    (write_data),
        .line_level    (line_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .line_pull_low (line_pull_low),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .no_device     (no_device),
        .read_data     (read_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Ticks spent in a phase; zero counts as one. A 10-bit register never
    // exceeds the 10-bit timer, so no saturation is needed here.
    function automatic int phase_len(phase_t p);
        logic [CFG_W-1:0] v;
        case (p)
            PH_RST_LOW:             v = dur_reg[REG_RESET_LOW];
            PH_RST_WAIT:            v = dur_reg[REG_PRESENCE_WAIT];
            PH_RST_TAIL:            v = dur_reg[REG_RESET_TAIL];
            PH_W_START, PH_R_START: v = dur_reg[REG_SLOT_START];
            PH_W_HOLD:              v = dur_reg[REG_WRITE_HOLD];
            PH_W_REC:               v = dur_reg[REG_RECOVERY];
            PH_R_WAIT:              v = dur_reg[REG_READ_SAMPLE];
            default:                v = dur_reg[REG_READ_TAIL];
        endcase
        return (v == '0) ? 1 : int'(v);
    endfunction

    // Advance the bus engine by one microsecond tick and return its result
    function automatic res_t bus_result_for(logic [1:0] md, logic [7:0] wd, logic lvl);
        res_t r;
        logic last;
        r = '0;
        // a command starts only from idle
        if (ph == PH_IDLE && md != MODE_TICK)
        begin
            us_cnt  = '0;
            bit_idx = '0;
            case (md)
                MODE_RESET: ph = PH_RST_LOW;
                MODE_WRITE:
                begin
                    ph    = PH_W_START;
                    tx_sh = wd;
                end
                default:
                begin
                    ph      = PH_R_START;
                    rx_byte = '0;
                end
            endcase
        end
        if (ph != PH_IDLE)
        begin
            r.busy = 1'b1;
            case (ph)
                PH_RST_LOW, PH_W_START, PH_R_START: r.pull = 1'b1;
                PH_W_HOLD:   r.pull = ~tx_sh[0];
                PH_RST_TAIL:
                begin
                    if (us_cnt == '0)
                        presence = lvl;
                end
                PH_R_TAIL:
                begin
                    if (us_cnt == '0 && lvl)
                        rx_byte[bit_idx] = 1'b1;
                end
                default: ;
            endcase
            us_cnt = us_cnt + 10'd1;
            // phase over: move on, bit slots loop until the eighth bit
            if (int'(us_cnt) >= phase_len(ph))
            begin
                us_cnt = '0;
                last   = (bit_idx == 3'd7);
                case (ph)
                    PH_RST_LOW:  ph = PH_RST_WAIT;
                    PH_RST_WAIT: ph = PH_RST_TAIL;
                    PH_RST_TAIL: ph = PH_IDLE;
                    PH_W_START:  ph = PH_W_HOLD;
                    PH_W_HOLD:   ph = PH_W_REC;
                    PH_W_REC:
                    begin
                        tx_sh   = tx_sh >> 1;
                        bit_idx = bit_idx + 3'd1;
                        ph      = last ? PH_IDLE : PH_W_START;
                    end
                    PH_R_START:  ph = PH_R_WAIT;
                    PH_R_WAIT:   ph = PH_R_TAIL;
                    default:
                    begin
                        bit_idx = bit_idx + 3'd1;
                        ph      = last ? PH_IDLE : PH_R_START;
                    end
                endcase
                r.done = (ph == PH_IDLE);
            end
        end
        r.no_dev = presence;
        r.rdata  = rx_byte;
        return r;
    endfunction

    function automatic int draw_wait(bit pace);
        return pace ? int'($urandom_range(0, 11)) : 0;
    endfunction

    function automatic logic level_for(int kind);
        if (kind == LV_LOW)
            return 1'b0;
        if (kind == LV_HIGH)
            return 1'b1;
        return 1'($urandom);
    endfunction

    // Length of a whole operation in ticks under the current durations
    function automatic int op_ticks(logic [1:0] md);
        case (md)
            MODE_RESET: return phase_len(PH_RST_LOW) + phase_len(PH_RST_WAIT)
                               + phase_len(PH_RST_TAIL);
            MODE_WRITE: return 8 * (phase_len(PH_W_START) + phase_len(PH_W_HOLD)
                                    + phase_len(PH_W_REC));
            default:    return 8 * (phase_len(PH_R_START) + phase_len(PH_R_WAIT)
                                    + phase_len(PH_R_TAIL));
        endcase
    endfunction

    function automatic dur_set_t uniform_set(logic [CFG_W-1:0] v);
        dur_set_t s;
        for (int i = 0; i < NUM_CFG; i++)
            s[i] = v;
        return s;
    endfunction

    // Mostly very short durations, now and then longer ones
    function automatic dur_set_t random_set();
        dur_set_t s;
        int p;
        for (int i = 0; i < NUM_CFG; i++)
        begin
            p = $urandom_range(0, 99);
            if (p < 95)
                s[i] = CFG_W'($urandom_range(0, 5));
            else if (p < 99)
                s[i] = CFG_W'($urandom_range(6, 30));
            else
                s[i] = CFG_W'($urandom_range(31, 100));
        end
        return s;
    endfunction

    task automatic push_tick(logic [1:0] md, logic [7:0] wd, logic lvl);
        ticks_to_send.push_back({md, wd, lvl});
        ticks_queued++;
    endtask

    // One command followed by the rest of its ticks; busy ticks carry ignored
    // commands at the given rate, then a few plain ticks follow
    task automatic run_op(logic [1:0] md, logic [7:0] wd, int lvl_kind, int noise_pct,
                          int tail);
        int n;
        n = op_ticks(md);
        push_tick(md, wd, level_for(lvl_kind));
        for (int i = 1; i < n; i++)
        begin
            push_tick(($urandom_range(1, 100) <= noise_pct) ? 2'($urandom_range(1, 3))
                                                           : MODE_TICK,
                      8'($urandom), level_for(lvl_kind));
        end
        repeat (tail)
            push_tick(MODE_TICK, 8'($urandom), level_for(lvl_kind));
    endtask

    task automatic wait_drained();
        while (results_seen < ticks_queued)
            @(posedge clk);
    endtask

    // Drain and tick on until the engine is idle
    task automatic settle();
        wait_drained();
        while (ph != PH_IDLE)
        begin
            repeat (16)
                push_tick(MODE_TICK, 8'h00, 1'($urandom));
            wait_drained();
        end
    endtask

    // Register write: setup cycle, then access cycle until pready
    task automatic reg_write(logic [2:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        dur_reg[idx] = val;
    endtask

    // Register read: setup cycle, then access cycle; data checked at the access edge
    task automatic reg_check(logic [2:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== DATA_W'(val))
        begin
            fail_count++;
            $display("%0t: register %0d expected %0h, got %0h", $time, idx, val, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_setting(dur_set_t s);
        settle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        for (int i = 0; i < NUM_CFG; i++)
            reg_write(3'(i), s[i]);
    endtask

    task automatic check_field(string what, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            fail_count++;
            $display("%0t: %s expected %0h, got %0h", $time, what, want_v, got_v);
        end
    endtask

    // Tick driver: works out the result of every item the block takes
    int    gap_left = 0;
    tick_t next_t;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                due_results.push_back(bus_result_for(mode, write_data, line_level));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (ticks_to_send.size() > 0)
                begin
                    next_t = ticks_to_send.pop_front();
                    mode       <= next_t.md;
                    write_data <= next_t.wd;
                    line_level <= next_t.lvl;
                    in_valid   <= 1'b1;
                    gap_left   = draw_wait(in_pace);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random stalls and requested long hold-offs
    int   stall_left = 0;
    int   hold_left  = 0;
    int   holds_seen = 0;
    res_t got;
    res_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {line_pull_low, busy_res, done_res, no_device, read_data};
                results_seen++;
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with nothing due, expected none, got %0h",
                             $time, got);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("line_pull_low", 8'(want.pull), 8'(got.pull));
                    check_field("busy_res", 8'(want.busy), 8'(got.busy));
                    check_field("done_res", 8'(want.done), 8'(got.done));
                    check_field("no_device", 8'(want.no_dev), 8'(got.no_dev));
                    check_field("read_data", want.rdata, got.rdata);
                end
                stall_left = draw_wait(out_pace);
            end
            if (hold_reqs != holds_seen)
            begin
                holds_seen = hold_reqs;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        dur_set_t s;
        int seg_start;
        int pick;

        dur_reg[REG_RESET_LOW]     = 10'd480;
        dur_reg[REG_PRESENCE_WAIT] = 10'd70;
        dur_reg[REG_RESET_TAIL]    = 10'd410;
        dur_reg[REG_SLOT_START]    = 10'd2;
        dur_reg[REG_WRITE_HOLD]    = 10'd60;
        dur_reg[REG_RECOVERY]      = 10'd2;
        dur_reg[REG_READ_SAMPLE]   = 10'd12;
        dur_reg[REG_READ_TAIL]     = 10'd50;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register values out of reset
        for (int i = 0; i < NUM_CFG; i++)
            reg_check(3'(i), dur_reg[i]);

        // one-tick phases: presence and no device, byte extremes
        load_setting(uniform_set(10'd1));
        run_op(MODE_RESET, 8'h00, LV_HIGH, 0, 0);
        run_op(MODE_RESET, 8'h00, LV_LOW, 0, 1);
        run_op(MODE_WRITE, 8'h00, LV_RANDOM, 0, 0);
        run_op(MODE_WRITE, 8'hFF, LV_RANDOM, 0, 1);
        run_op(MODE_READ, 8'h00, LV_HIGH, 0, 0);
        run_op(MODE_READ, 8'h00, LV_LOW, 0, 1);
        // commands on every busy tick, the finishing one too; the next starts right after
        run_op(MODE_WRITE, 8'h3C, LV_RANDOM, 100, 0);
        run_op(MODE_READ, 8'h00, LV_RANDOM, 100, 0);
        run_op(MODE_RESET, 8'h00, LV_RANDOM, 100, 3);

        // zero-valued durations act as one tick
        load_setting(uniform_set(10'd0));
        run_op(MODE_RESET, 8'h00, LV_RANDOM, 20, 0);
        run_op(MODE_WRITE, 8'h96, LV_RANDOM, 20, 0);
        run_op(MODE_READ, 8'h00, LV_RANDOM, 20, 2);

        // receiver holds off while the sender keeps offering ticks
        s = uniform_set(10'd2);
        s[REG_RESET_LOW]   = 10'd5;
        s[REG_WRITE_HOLD]  = 10'd4;
        s[REG_READ_SAMPLE] = 10'd3;
        s[REG_READ_TAIL]   = 10'd1;
        load_setting(s);
        in_pace  = 1'b0;
        out_pace = 1'b0;
        hold_reqs++;
        run_op(MODE_READ, 8'h00, LV_RANDOM, 10, 0);
        run_op(MODE_WRITE, 8'h69, LV_RANDOM, 10, 0);
        run_op(MODE_RESET, 8'h00, LV_RANDOM, 10, 0);
        // sender waits for every result before going on
        wait_drained();
        in_pace  = 1'b1;
        out_pace = 1'b1;
        run_op(MODE_WRITE, 8'hC3, LV_RANDOM, 10, 1);

        // longest low time, the counter runs up to its top value; no idling
        in_pace  = 1'b0;
        out_pace = 1'b0;
        s = uniform_set(10'd1);
        s[REG_RESET_LOW] = 10'd1023;
        load_setting(s);
        run_op(MODE_RESET, 8'h00, LV_LOW, 1, 0);

        // random segments, each under a fresh setting
        for (int seg = 0; seg < RANDOM_SEGS; seg++)
        begin
            load_setting(random_set());
            in_pace   = ($urandom_range(0, 2) != 0);
            out_pace  = ($urandom_range(0, 2) != 0);
            seg_start = ticks_queued;
            while (ticks_queued - seg_start < RANDOM_TICKS / RANDOM_SEGS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    run_op(2'($urandom_range(1, 3)), 8'($urandom), LV_RANDOM,
                           $urandom_range(0, 30), $urandom_range(0, 3));
                end
                else if (pick < 93)
                begin
                    // loose ticks with arbitrary commands
                    repeat ($urandom_range(1, 8))
                        push_tick(2'($urandom), 8'($urandom), 1'($urandom));
                end
                else if (pick < 97)
                begin
                    wait_drained();
                    in_pace = ($urandom_range(0, 1) != 0);
                end
                else
                begin
                    hold_reqs++;
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && due_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
